// ----- rtl/rmj_pkg.sv -----
// ============================================================================
// rmj_pkg
// Shared widths, latencies and types for the radar measurement Jacobian.
// ============================================================================
package rmj_pkg;

    // Number format: signed Q15.16
    localparam int DATA_W    = 32;
    localparam int FRAC_W    = 16;

    // Magnitudes hold the full range including the most negative value
    localparam int MAG_W     = DATA_W;
    localparam int SQ_W      = 2 * MAG_W;

    // Limb-split multiplier
    localparam int LIMB_W    = 32;
    localparam int MA_LIMBS  = 4;
    localparam int MB_LIMBS  = 2;
    localparam int MA_W      = MA_LIMBS * LIMB_W;
    localparam int MB_W      = MB_LIMBS * LIMB_W;
    localparam int MP_W      = MA_W + MB_W;
    localparam int MUL_LAT   = 4;

    // Divider: quotient of a squared entry, overflow forces all ones
    localparam int QUO_W     = 2 * DATA_W - 1;
    localparam int DEN_W     = MP_W;
    localparam int DIV_W     = DEN_W + QUO_W;
    localparam int DIV_LAT   = QUO_W + 1;

    // Integer square root
    localparam int ROOT_W    = DATA_W;
    localparam int RAD_W     = 2 * ROOT_W;
    localparam int SQRT_LAT  = ROOT_W;

    // Whole pipeline
    localparam int LANE_LAT  = DIV_LAT + SQRT_LAT + 1;
    localparam int FRONT_LAT = 3;
    localparam int TOT_LAT   = FRONT_LAT + 2 * MUL_LAT + LANE_LAT;
    localparam int N_LANES   = 6;

    // Stream widths
    localparam int IN_W      = 4 * DATA_W;
    localparam int OUT_W     = N_LANES * DATA_W;
    localparam int USER_W    = 1;

    // Per-lane sideband
    typedef struct packed {
        logic neg;
        logic err;
    } t_lane_ctl;

endpackage

// ----- rtl/rmj_mul.sv -----
// ============================================================================
// rmj_mul
// Pipelined unsigned multiplier built from 32x32 partial products.
// Stage 1 forms the partial products, stages 2 to 4 sum them up.
// ============================================================================
module rmj_mul (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [rmj_pkg::MA_W-1:0]  i_a,
    input  logic [rmj_pkg::MB_W-1:0]  i_b,
    output logic [rmj_pkg::MP_W-1:0]  o_p
);
    import rmj_pkg::*;

    localparam int PP_W   = 2 * LIMB_W;
    localparam int ROW_W  = MB_W + LIMB_W;
    localparam int HALF_W = ROW_W + LIMB_W;

    logic [PP_W-1:0]   r_pp  [MA_LIMBS][MB_LIMBS];
    logic [ROW_W-1:0]  r_row [MA_LIMBS];
    logic [ROW_W-1:0]  n_row [MA_LIMBS];
    logic [HALF_W-1:0] r_half [2];
    logic [MP_W-1:0]   r_p;

    // Row sums of one A limb against all B limbs
    always_comb begin
        for (int i = 0; i < MA_LIMBS; i++) begin
            n_row[i] = '0;
            for (int j = 0; j < MB_LIMBS; j++) begin
                n_row[i] = n_row[i] + (ROW_W'(r_pp[i][j]) << (j * LIMB_W));
            end
        end
    end

    // Partial products, row sums, pair sums, final sum
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < MA_LIMBS; i++) begin
                for (int j = 0; j < MB_LIMBS; j++) begin
                    r_pp[i][j] <= PP_W'(i_a[i*LIMB_W +: LIMB_W])
                                * PP_W'(i_b[j*LIMB_W +: LIMB_W]);
                end
                r_row[i] <= n_row[i];
            end
            for (int h = 0; h < 2; h++) begin
                r_half[h] <= HALF_W'(r_row[2*h]) + (HALF_W'(r_row[2*h+1]) << LIMB_W);
            end
            r_p <= MP_W'(r_half[0]) + (MP_W'(r_half[1]) << (2 * LIMB_W));
        end
    end

    assign o_p = r_p;

endmodule

// ----- rtl/rmj_div.sv -----
// ============================================================================
// rmj_div
// Pipelined restoring divider, one quotient bit per stage.
// A quotient that does not fit is returned as all ones.
// ============================================================================
module rmj_div (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [rmj_pkg::DIV_W-1:0]  i_num,
    input  logic [rmj_pkg::DEN_W-1:0]  i_den,
    output logic [rmj_pkg::QUO_W-1:0]  o_quo
);
    import rmj_pkg::*;

    logic [DIV_W-1:0] r_rem [DIV_LAT];
    logic [DEN_W-1:0] r_den [DIV_LAT];
    logic [QUO_W-1:0] r_quo [DIV_LAT];
    logic             r_ovf [DIV_LAT];
    logic [DIV_W-1:0] den_top;

    // Overflow when the quotient needs more than QUO_W bits
    assign den_top = DIV_W'(i_den) << QUO_W;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= i_num;
            r_den[0] <= i_den;
            r_quo[0] <= '0;
            r_ovf[0] <= (i_num >= den_top);
        end
    end

    // One compare and subtract per stage, top quotient bit first
    for (genvar k = 1; k < DIV_LAT; k++) begin : g_stage
        localparam int SH = QUO_W - k;
        logic [DIV_W-1:0] den_sh;
        logic             take;

        assign den_sh = DIV_W'(r_den[k-1]) << SH;
        assign take   = (r_rem[k-1] >= den_sh);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= take ? (r_rem[k-1] - den_sh) : r_rem[k-1];
                r_den[k] <= r_den[k-1];
                r_quo[k] <= r_quo[k-1] | (QUO_W'(take) << SH);
                r_ovf[k] <= r_ovf[k-1];
            end
        end
    end

    assign o_quo = r_ovf[DIV_LAT-1] ? '1 : r_quo[DIV_LAT-1];

endmodule

// ----- rtl/rmj_sqrt.sv -----
// ============================================================================
// rmj_sqrt
// Pipelined integer square root, one root bit per stage.
// Returns the largest root whose square does not exceed the radicand.
// ============================================================================
module rmj_sqrt (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [rmj_pkg::RAD_W-1:0]   i_rad,
    output logic [rmj_pkg::ROOT_W-1:0]  o_root
);
    import rmj_pkg::*;

    logic [RAD_W-1:0]  r_rem  [SQRT_LAT];
    logic [ROOT_W-1:0] r_root [SQRT_LAT];

    for (genvar k = 0; k < SQRT_LAT; k++) begin : g_stage
        localparam int B = ROOT_W - 1 - k;
        logic [RAD_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [RAD_W-1:0]  trial;
        logic              take;

        if (k == 0) begin : g_first
            assign rem_in  = i_rad;
            assign root_in = '0;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
        end

        // (root + 2^B)^2 - root^2
        assign trial = (RAD_W'(root_in) << (B + 1)) | (RAD_W'(1) << (2 * B));
        assign take  = (rem_in >= trial);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= take ? (rem_in - trial) : rem_in;
                r_root[k] <= root_in | (ROOT_W'(take) << B);
            end
        end
    end

    assign o_root = r_root[SQRT_LAT-1];

endmodule

// ----- rtl/rmj_lane.sv -----
// ============================================================================
// rmj_lane
// One Jacobian entry: divide, square root, then sign and saturate.
// The entry magnitude is the root of the floored quotient num / den.
// ============================================================================
module rmj_lane (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [rmj_pkg::DIV_W-1:0]   i_num,
    input  logic [rmj_pkg::DEN_W-1:0]   i_den,
    input  rmj_pkg::t_lane_ctl          i_ctl,
    output logic [rmj_pkg::DATA_W-1:0]  o_val,
    output logic                        o_err
);
    import rmj_pkg::*;

    localparam int CTL_LAT = DIV_LAT + SQRT_LAT;
    localparam logic [ROOT_W-1:0] POS_LIM = {1'b0, {(ROOT_W-1){1'b1}}};
    localparam logic [ROOT_W-1:0] NEG_LIM = {1'b1, {(ROOT_W-1){1'b0}}};

    logic [QUO_W-1:0]  quo;
    logic [ROOT_W-1:0] root;
    t_lane_ctl         r_ctl [CTL_LAT];
    logic [ROOT_W-1:0] lim;
    logic [ROOT_W-1:0] mag;
    logic [DATA_W-1:0] n_val;
    logic [DATA_W-1:0] r_val;
    logic              r_err;

    rmj_div u_div (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_num (i_num),
        .i_den (i_den),
        .o_quo (quo)
    );

    rmj_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_rad  (RAD_W'(quo)),
        .o_root (root)
    );

    // Sign and error flags follow the arithmetic
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctl[0] <= i_ctl;
            for (int i = 1; i < CTL_LAT; i++) begin
                r_ctl[i] <= r_ctl[i-1];
            end
        end
    end

    // Clip magnitude to the signed range, apply sign; an error forces zero
    always_comb begin
        lim   = r_ctl[CTL_LAT-1].neg ? NEG_LIM : POS_LIM;
        mag   = (root > lim) ? lim : root;
        n_val = r_ctl[CTL_LAT-1].neg ? DATA_W'(-mag) : DATA_W'(mag);
        if (r_ctl[CTL_LAT-1].err) begin
            n_val = '0;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_val <= n_val;
            r_err <= r_ctl[CTL_LAT-1].err;
        end
    end

    assign o_val = r_val;
    assign o_err = r_err;

endmodule

// ----- rtl/radar_measurement_jacobian.sv -----
// ============================================================================
// radar_measurement_jacobian
// Radar measurement Jacobian of a constant-velocity state in Q15.16.
// ============================================================================
// Usage:
//   Slave channel (i_s_*): one state beat per transfer, tdata holds
//   pos_x, pos_y, vel_x, vel_y from the lowest bit up.
//   Master channel (o_m_*): one result beat per state, tdata holds the six
//   nonzero Jacobian entries, tuser the error flag for a zero pos_x or pos_y.
//   An accepted beat reaches the master side through 3 front-end stages,
//   two 4-stage multiplier rounds, a 64-stage divider, a 32-stage square
//   root and the output register. Every stage is its own register.
//   Throughput is one beat per cycle while the receiver does not stall.
//   When the receiver stalls the whole pipeline holds; o_s_tready drops
//   only while a result waits in the output register. Nothing is lost or
//   repeated. Reset clears all valid bits; no beat is presented after it
//   until new input arrives.
// ============================================================================
module radar_measurement_jacobian (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Input state
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [rmj_pkg::IN_W-1:0]    i_s_tdata,  // pos_x, pos_y, vel_x, vel_y
    // Jacobian entries
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [rmj_pkg::OUT_W-1:0]   o_m_tdata,  // range_by_x, range_by_y,
                                                    // bearing_by_x, bearing_by_y,
                                                    // rate_by_x, rate_by_y
    output logic [rmj_pkg::USER_W-1:0]  o_m_tuser   // div_error
);
    import rmj_pkg::*;

    typedef struct packed {
        logic [SQ_W-1:0] p2;
        logic [SQ_W-1:0] q2;
        logic [SQ_W-1:0] s;
        logic [MA_W-1:0] s2;
        logic            np;
        logic            nq;
        logic            dneg;
        logic            err;
    } t_side;

    localparam logic signed [DATA_W-1:0] ONE_Q = DATA_W'(1) << FRAC_W;

    logic                adv;
    logic [TOT_LAT-1:0]  r_vld;

    logic [MAG_W-1:0]    r1_mag [4];
    logic                r1_neg [4];
    logic                r1_err;

    logic [SQ_W-1:0]     r2_p2, r2_q2, r2_t1, r2_t2;
    logic                r2_np, r2_nq, r2_s1n, r2_s2n, r2_err;

    logic [SQ_W-1:0]     r3_s, r3_dm, r3_p2, r3_q2;
    logic                r3_np, r3_nq, r3_dneg, r3_err;
    logic [SQ_W-1:0]     n_dm;
    logic                n_dneg;

    logic [MP_W-1:0]     s2_p, d2_p, s3_p, qd_p, pd_p;
    t_side               n_side1;
    t_side               r_dly1 [MUL_LAT];
    t_side               n_side2;
    t_side               r_dly2 [MUL_LAT];

    logic [DIV_W-1:0]    lane_num [N_LANES];
    logic [DEN_W-1:0]    lane_den [N_LANES];
    t_lane_ctl           lane_ctl [N_LANES];
    logic [DATA_W-1:0]   lane_val [N_LANES];
    logic                lane_err [N_LANES];

    logic signed [DATA_W-1:0] out_rx, out_by;

    // Whole pipeline moves unless a result waits in the output register and the receiver is not ready
    assign adv        = !r_vld[TOT_LAT-1] || i_m_tready;
    assign o_s_tready = adv;
    assign o_m_tvalid = r_vld[TOT_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[TOT_LAT-2:0], i_s_tvalid};
        end
    end

    // Stage 1: sign and magnitude of each field, and the error flag for a zero pos_x or pos_y
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i < 4; i++) begin
                r1_neg[i] <= i_s_tdata[i*DATA_W + DATA_W - 1];
                r1_mag[i] <= i_s_tdata[i*DATA_W + DATA_W - 1]
                           ? MAG_W'(~i_s_tdata[i*DATA_W +: DATA_W] + 1'b1)
                           : MAG_W'(i_s_tdata[i*DATA_W +: DATA_W]);
            end
            r1_err <= (i_s_tdata[0 +: DATA_W] == '0) || (i_s_tdata[DATA_W +: DATA_W] == '0);
        end
    end

    // Stage 2: squares and cross products
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_p2  <= SQ_W'(r1_mag[0]) * SQ_W'(r1_mag[0]);
            r2_q2  <= SQ_W'(r1_mag[1]) * SQ_W'(r1_mag[1]);
            r2_t1  <= SQ_W'(r1_mag[2]) * SQ_W'(r1_mag[1]);
            r2_t2  <= SQ_W'(r1_mag[3]) * SQ_W'(r1_mag[0]);
            r2_np  <= r1_neg[0];
            r2_nq  <= r1_neg[1];
            r2_s1n <= r1_neg[2] ^ r1_neg[1];
            r2_s2n <= r1_neg[3] ^ r1_neg[0];
            r2_err <= r1_err;
        end
    end

    // Stage 3: squared range and vx*py - vy*px as sign and magnitude
    always_comb begin
        if (r2_s1n != r2_s2n) begin
            n_dm   = r2_t1 + r2_t2;
            n_dneg = r2_s1n;
        end else if (r2_t1 >= r2_t2) begin
            n_dm   = r2_t1 - r2_t2;
            n_dneg = r2_s1n;
        end else begin
            n_dm   = r2_t2 - r2_t1;
            n_dneg = !r2_s1n;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r3_s    <= r2_p2 + r2_q2;
            r3_dm   <= n_dm;
            r3_dneg <= n_dneg;
            r3_p2   <= r2_p2;
            r3_q2   <= r2_q2;
            r3_np   <= r2_np;
            r3_nq   <= r2_nq;
            r3_err  <= r2_err;
        end
    end

    // First multiplier round: s^2 and d^2
    rmj_mul u_mul_s2 (
        .i_clk (i_clk), .i_en (adv),
        .i_a   (MA_W'(r3_s)), .i_b (r3_s), .o_p (s2_p)
    );
    rmj_mul u_mul_d2 (
        .i_clk (i_clk), .i_en (adv),
        .i_a   (MA_W'(r3_dm)), .i_b (r3_dm), .o_p (d2_p)
    );

    always_comb begin
        n_side1      = '0;
        n_side1.p2   = r3_p2;
        n_side1.q2   = r3_q2;
        n_side1.s    = r3_s;
        n_side1.np   = r3_np;
        n_side1.nq   = r3_nq;
        n_side1.dneg = r3_dneg;
        n_side1.err  = r3_err;
    end

    // Second multiplier round: s^3, q^2 d^2, p^2 d^2
    rmj_mul u_mul_s3 (
        .i_clk (i_clk), .i_en (adv),
        .i_a   (MA_W'(s2_p)), .i_b (r_dly1[MUL_LAT-1].s), .o_p (s3_p)
    );
    rmj_mul u_mul_qd (
        .i_clk (i_clk), .i_en (adv),
        .i_a   (MA_W'(d2_p)), .i_b (r_dly1[MUL_LAT-1].q2), .o_p (qd_p)
    );
    rmj_mul u_mul_pd (
        .i_clk (i_clk), .i_en (adv),
        .i_a   (MA_W'(d2_p)), .i_b (r_dly1[MUL_LAT-1].p2), .o_p (pd_p)
    );

    always_comb begin
        n_side2    = r_dly1[MUL_LAT-1];
        n_side2.s2 = MA_W'(s2_p);
    end

    // Sideband delay lines beside the multipliers
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dly1[0] <= n_side1;
            r_dly2[0] <= n_side2;
            for (int i = 1; i < MUL_LAT; i++) begin
                r_dly1[i] <= r_dly1[i-1];
                r_dly2[i] <= r_dly2[i-1];
            end
        end
    end

    // Numerators, denominators and signs of the six entries
    always_comb begin
        lane_num[0] = DIV_W'(r_dly2[MUL_LAT-1].p2) << (2 * FRAC_W);
        lane_den[0] = DEN_W'(r_dly2[MUL_LAT-1].s);
        lane_ctl[0].neg = r_dly2[MUL_LAT-1].np;

        lane_num[1] = DIV_W'(r_dly2[MUL_LAT-1].q2) << (2 * FRAC_W);
        lane_den[1] = DEN_W'(r_dly2[MUL_LAT-1].s);
        lane_ctl[1].neg = r_dly2[MUL_LAT-1].nq;

        lane_num[2] = DIV_W'(r_dly2[MUL_LAT-1].q2) << (4 * FRAC_W);
        lane_den[2] = DEN_W'(r_dly2[MUL_LAT-1].s2);
        lane_ctl[2].neg = !r_dly2[MUL_LAT-1].nq;

        lane_num[3] = DIV_W'(r_dly2[MUL_LAT-1].p2) << (4 * FRAC_W);
        lane_den[3] = DEN_W'(r_dly2[MUL_LAT-1].s2);
        lane_ctl[3].neg = r_dly2[MUL_LAT-1].np;

        lane_num[4] = DIV_W'(qd_p) << (2 * FRAC_W);
        lane_den[4] = DEN_W'(s3_p);
        lane_ctl[4].neg = r_dly2[MUL_LAT-1].nq ^ r_dly2[MUL_LAT-1].dneg;

        lane_num[5] = DIV_W'(pd_p) << (2 * FRAC_W);
        lane_den[5] = DEN_W'(s3_p);
        lane_ctl[5].neg = !(r_dly2[MUL_LAT-1].np ^ r_dly2[MUL_LAT-1].dneg);

        for (int i = 0; i < N_LANES; i++) begin
            lane_ctl[i].err = r_dly2[MUL_LAT-1].err;
        end
    end

    for (genvar l = 0; l < N_LANES; l++) begin : g_lane
        rmj_lane u_lane (
            .i_clk (i_clk),
            .i_en  (adv),
            .i_num (lane_num[l]),
            .i_den (lane_den[l]),
            .i_ctl (lane_ctl[l]),
            .o_val (lane_val[l]),
            .o_err (lane_err[l])
        );
        assign o_m_tdata[l*DATA_W +: DATA_W] = lane_val[l];
    end

    assign o_m_tuser = USER_W'(lane_err[0]);

    assign out_rx = $signed(o_m_tdata[0 +: DATA_W]);
    assign out_by = $signed(o_m_tdata[3*DATA_W +: DATA_W]);

    // Checks
    a_rst_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |-> o_m_tdata == '0)
        else $error("nonzero entries with error flag");

    a_range_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (out_rx <= ONE_Q) && (out_rx >= -ONE_Q))
        else $error("range_by_x beyond unit magnitude");

    a_sign_px: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !((out_rx > 0) && (out_by < 0)) && !((out_rx < 0) && (out_by > 0)))
        else $error("range_by_x and bearing_by_y disagree in sign");

endmodule
